FILE: design/crl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crl_pkg
// Shared constants, types and register codes for the command rate limiter.
// ----------------------------------------------------------------------------
package crl_pkg;

  // field widths
  localparam int unsigned TIME_W      = 64;
  localparam int unsigned BURST_W     = 16;
  localparam int unsigned RATE_W      = 16;
  localparam int unsigned MINUTE_W    = 20;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 20;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 8;

  // time constants
  localparam logic [TIME_W-1:0] SECOND_NS = 64'd1000000000;
  localparam logic [TIME_W-1:0] MINUTE_NS = 64'd60000000000;

  // elapsed (rate nonzero) or product at or above this gives a refill of 65536 or more
  localparam logic [TIME_W-1:0] REFILL_SAT_NS = 64'd65536000000000;

  // refill datapath widths
  localparam int unsigned ELAPSED_W = 46;          // ceil(log2(REFILL_SAT_NS))
  localparam int unsigned SPLIT_W   = 23;          // elapsed split for the multiply
  localparam int unsigned PP_W      = SPLIT_W + RATE_W;
  localparam int unsigned PROD_W    = ELAPSED_W + RATE_W;
  localparam int unsigned QSHIFT    = 14;          // product bits dropped before the reciprocal
  localparam int unsigned QX_W      = ELAPSED_W - QSHIFT;
  localparam int unsigned RECIP_SHIFT = 47;
  localparam logic [31:0] RECIP     = 32'd2305843009; // floor(2^(47+14) / 1e9)
  localparam int unsigned NSEC_W    = 30;
  localparam logic [NSEC_W-1:0] SECOND_NS_N = 30'd1000000000;

  // stages from input transfer to result register
  localparam int unsigned PIPE_DEPTH = 6;

  // configuration register codes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BURST   = 2'd0,
    CFG_PER_SEC = 2'd1,
    CFG_PER_MIN = 2'd2
  } crl_cfg_index_t;

  // configuration register set
  typedef struct packed {
    logic [BURST_W-1:0]  burst;
    logic [RATE_W-1:0]   per_sec;
    logic [MINUTE_W-1:0] per_min;
  } crl_cfg_t;

  // per-request control flags that travel down the pipeline
  typedef struct packed {
    logic init;      // first request after start: bucket to full
    logic sec_clr;   // one-second count restarts
    logic min_clr;   // sixty-second count restarts
  } crl_flags_t;

endpackage

FILE: design/crl_time.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crl_time
// Time stage: tracks last update time and both window starts, and produces
// the elapsed time and window restart flags for each request.
// ----------------------------------------------------------------------------
module crl_time (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [crl_pkg::TIME_W-1:0] now_ns,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [crl_pkg::TIME_W-1:0] elapsed,
  output crl_pkg::crl_flags_t       flags
);
  import crl_pkg::*;

  logic [TIME_W-1:0] last_update_time;
  logic [TIME_W-1:0] second_window_start;
  logic [TIME_W-1:0] minute_window_start;
  logic              en;
  logic              init;
  logic              sec_clr;
  logic              min_clr;
  logic [TIME_W-1:0] sec_age;
  logic [TIME_W-1:0] min_age;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // window ages wrap modulo 2^64
  assign init    = (last_update_time == '0);
  assign sec_age = now_ns - second_window_start;
  assign min_age = now_ns - minute_window_start;
  assign sec_clr = init || (sec_age >= SECOND_NS);
  assign min_clr = init || (min_age >= MINUTE_NS);

  // time state and stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid           <= 1'b0;
      last_update_time    <= '0;
      second_window_start <= '0;
      minute_window_start <= '0;
    end else if (en) begin
      out_valid <= in_valid;
      if (in_valid) begin
        elapsed          <= init ? '0 : (now_ns - last_update_time);
        flags.init       <= init;
        flags.sec_clr    <= sec_clr;
        flags.min_clr    <= min_clr;
        last_update_time <= now_ns;
        if (sec_clr) begin
          second_window_start <= now_ns;
        end
        if (min_clr) begin
          minute_window_start <= now_ns;
        end
      end
    end
  end

endmodule

FILE: design/crl_refill.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crl_refill
// Refill pipeline: floor(elapsed * rate / 1e9) saturated to the burst limit,
// in four stages (split multiply, sum, reciprocal multiply, correction).
// ----------------------------------------------------------------------------
module crl_refill (
  input  logic                        clk,
  input  logic                        rst,
  input  crl_pkg::crl_cfg_t           cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [crl_pkg::TIME_W-1:0]  elapsed,
  input  crl_pkg::crl_flags_t         in_flags,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [crl_pkg::BURST_W-1:0] refill,
  output crl_pkg::crl_flags_t         out_flags
);
  import crl_pkg::*;

  // stage valids and enables
  logic v2, v3, v4;
  logic en2, en3, en4, en5;

  // stage 2: partial products
  logic [PP_W-1:0]   pp_lo;
  logic [PP_W-1:0]   pp_hi;
  logic              sat2;
  crl_flags_t        flags2;

  // stage 3: full product
  logic [ELAPSED_W-1:0] prod3;
  logic                 sat3;
  crl_flags_t           flags3;

  // stage 4: quotient estimate
  logic [BURST_W-1:0]   q_est;
  logic [ELAPSED_W-1:0] prod4;
  logic                 sat4;
  crl_flags_t           flags4;

  // combinational terms
  logic [PROD_W-1:0]    prod_sum;
  logic                 prod_big;
  logic [63:0]          recip_prod;
  logic [ELAPSED_W-1:0] q_ns;
  logic [ELAPSED_W-1:0] rem;
  logic [BURST_W:0]     q_fix;

  assign en5      = !out_valid || out_ready;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign in_ready = en2;

  // sum of partial products, and saturation on q of 65536 or more
  assign prod_sum = {{(PROD_W-PP_W){1'b0}}, pp_lo}
                  + {pp_hi, {SPLIT_W{1'b0}}};
  assign prod_big = (prod_sum >= REFILL_SAT_NS[PROD_W-1:0]);

  // reciprocal estimate, never above the true quotient and at most one below
  assign recip_prod = {{(64-QX_W){1'b0}}, prod3[ELAPSED_W-1:QSHIFT]}
                    * {32'd0, RECIP};

  // remainder correction
  assign q_ns  = q_est * SECOND_NS_N;
  assign rem   = prod4 - q_ns;
  assign q_fix = {1'b0, q_est} + {{BURST_W{1'b0}}, (rem >= SECOND_NS[ELAPSED_W-1:0])};

  // pipeline registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en2) begin
        v2     <= in_valid;
        pp_lo  <= elapsed[SPLIT_W-1:0] * cfg.per_sec;
        pp_hi  <= elapsed[ELAPSED_W-1:SPLIT_W] * cfg.per_sec;
        sat2   <= (elapsed >= REFILL_SAT_NS) && (cfg.per_sec != '0);
        flags2 <= in_flags;
      end
      if (en3) begin
        v3     <= v2;
        prod3  <= prod_sum[ELAPSED_W-1:0];
        sat3   <= sat2 || prod_big;
        flags3 <= flags2;
      end
      if (en4) begin
        v4     <= v3;
        q_est  <= recip_prod[RECIP_SHIFT+BURST_W-1:RECIP_SHIFT];
        prod4  <= prod3;
        sat4   <= sat3;
        flags4 <= flags3;
      end
      if (en5) begin
        out_valid <= v4;
        out_flags <= flags4;
        if (sat4 || (q_fix > {1'b0, cfg.burst})) begin
          refill <= cfg.burst;
        end else begin
          refill <= q_fix[BURST_W-1:0];
        end
      end
    end
  end

endmodule

FILE: design/crl_bucket.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crl_bucket
// Token bucket and window grant counters, with the result register.
// ----------------------------------------------------------------------------
module crl_bucket (
  input  logic                            clk,
  input  logic                            rst,
  input  crl_pkg::crl_cfg_t               cfg,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [crl_pkg::BURST_W-1:0]     refill,
  input  crl_pkg::crl_flags_t             flags,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [crl_pkg::OUT_TDATA_W-1:0] out_data
);
  import crl_pkg::*;

  logic [BURST_W-1:0]  token_count;
  logic [RATE_W-1:0]   second_grants;
  logic [MINUTE_W-1:0] minute_grants;
  logic                en;
  logic [BURST_W-1:0]  tok_base;
  logic [BURST_W:0]    tok_sum;
  logic [BURST_W-1:0]  tok_capped;
  logic [RATE_W-1:0]   sec_cnt;
  logic [MINUTE_W-1:0] min_cnt;
  logic                grant;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // refill with cap at the burst limit
  assign tok_base   = flags.init ? cfg.burst : token_count;
  assign tok_sum    = {1'b0, tok_base} + {1'b0, refill};
  assign tok_capped = (tok_sum > {1'b0, cfg.burst}) ? cfg.burst : tok_sum[BURST_W-1:0];

  // window counts after restart
  assign sec_cnt = flags.sec_clr ? '0 : second_grants;
  assign min_cnt = flags.min_clr ? '0 : minute_grants;

  // grant decision
  assign grant = (tok_capped != '0) && (sec_cnt < cfg.per_sec) && (min_cnt < cfg.per_min);

  // bucket state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      token_count   <= '0;
      second_grants <= '0;
      minute_grants <= '0;
    end else if (en) begin
      out_valid <= in_valid;
      if (in_valid) begin
        out_data      <= {{(OUT_TDATA_W-1){1'b0}}, grant};
        token_count   <= grant ? (tok_capped - 1'b1) : tok_capped;
        second_grants <= grant ? (sec_cnt + 1'b1) : sec_cnt;
        minute_grants <= grant ? (min_cnt + 1'b1) : min_cnt;
      end
    end
  end

endmodule

FILE: design/command_rate_limiter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_rate_limiter_core
// Token bucket command rate limiter with one-second and sixty-second windows.
// ----------------------------------------------------------------------------
// Takes one request per cycle on the slave stream unless a stall holds it, and
// returns one grant bit per request on the master stream, in order. Each
// request passes the time stage, the four-stage refill pipeline that works
// out floor(elapsed * per_second_limit / 1e9) through a split multiply
// and a reciprocal multiply with one correction step, and the bucket stage
// that holds the result register. Stalls on the master side propagate back
// stage by stage, so bubbles are filled while a result waits. Registers are
// written through the cfg channel, which is always ready; write them only
// while no request is in flight. There is no clearing pass after reset.
module command_rate_limiter_core (
  input  logic                                clk,
  input  logic                                rst,
  // request stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [crl_pkg::IN_TDATA_W-1:0]      s_tdata,   // [63:0] now_ns
  // result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [crl_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [0] allowed, [7:1] zero
  // register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [crl_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [crl_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import crl_pkg::*;

  crl_cfg_t          cfg;
  logic              t_valid;
  logic              t_ready;
  logic [TIME_W-1:0] t_elapsed;
  crl_flags_t        t_flags;
  logic              r_valid;
  logic              r_ready;
  logic [BURST_W-1:0] r_refill;
  crl_flags_t        r_flags;
  logic [2:0]        inflight;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.burst   <= 16'd20;
      cfg.per_sec <= 16'd10;
      cfg.per_min <= 20'd100;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BURST:   cfg.burst   <= cfg_data[BURST_W-1:0];
        CFG_PER_SEC: cfg.per_sec <= cfg_data[RATE_W-1:0];
        CFG_PER_MIN: cfg.per_min <= cfg_data[MINUTE_W-1:0];
        default: ;
      endcase
    end
  end

  // time stage
  crl_time u_time (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .now_ns    (s_tdata[TIME_W-1:0]),
    .out_valid (t_valid),
    .out_ready (t_ready),
    .elapsed   (t_elapsed),
    .flags     (t_flags)
  );

  // refill pipeline
  crl_refill u_refill (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (t_valid),
    .in_ready  (t_ready),
    .elapsed   (t_elapsed),
    .in_flags  (t_flags),
    .out_valid (r_valid),
    .out_ready (r_ready),
    .refill    (r_refill),
    .out_flags (r_flags)
  );

  // bucket and result register
  crl_bucket u_bucket (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (r_valid),
    .in_ready  (r_ready),
    .refill    (r_refill),
    .flags     (r_flags),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

  // requests in flight, for checking
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + {2'b00, (s_tvalid && s_tready)}
                           - {2'b00, (m_tvalid && m_tready)};
    end
  end

  // an empty result register means the whole pipeline can move
  assert property (@(posedge clk) disable iff (rst) !m_tvalid |-> s_tready)
    else $error("input stalled while result register empty");

  // never more requests in flight than pipeline stages
  assert property (@(posedge clk) disable iff (rst)
                   inflight <= PIPE_DEPTH[2:0])
    else $error("pipeline occupancy overflow");

  // a result is only shown for a request that is in flight
  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> (inflight != '0))
    else $error("result without a pending request");

  // padding bits of the result stay zero
  assert property (@(posedge clk) disable iff (rst)
                   m_tvalid |-> (m_tdata[OUT_TDATA_W-1:1] == '0))
    else $error("result padding not zero");

endmodule
